@@ hw/rtl/fst_pkg.sv @@
// ----------------------------------------------------------------------------
// Fortran subset tokenizer package
// Token kinds, scan modes, result record and lexer character helpers.
// ----------------------------------------------------------------------------
package fst_pkg;

    localparam int KIND_BITS = 6;
    localparam int MAX_TOKENS = 4;
    localparam int CNT_BITS = 3;
    localparam int TLEN_BITS = 16;
    localparam int IVAL_BITS = 31;
    localparam logic [30:0] INT_MAXV = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [5:0] K_EOF = 6'd0;
    localparam logic [5:0] K_NL = 6'd1;
    localparam logic [5:0] K_ID = 6'd2;
    localparam logic [5:0] K_INT = 6'd3;
    localparam logic [5:0] K_STR = 6'd4;
    localparam logic [5:0] K_KW0 = 6'd5;
    localparam logic [5:0] K_PLUS = 6'd26;
    localparam logic [5:0] K_MINUS = 6'd27;
    localparam logic [5:0] K_STAR = 6'd28;
    localparam logic [5:0] K_SLASH = 6'd29;
    localparam logic [5:0] K_EQ = 6'd30;
    localparam logic [5:0] K_NE = 6'd31;
    localparam logic [5:0] K_LT = 6'd32;
    localparam logic [5:0] K_GT = 6'd33;
    localparam logic [5:0] K_LE = 6'd34;
    localparam logic [5:0] K_GE = 6'd35;
    localparam logic [5:0] K_AND = 6'd36;
    localparam logic [5:0] K_OR = 6'd37;
    localparam logic [5:0] K_NOT = 6'd38;
    localparam logic [5:0] K_ASSIGN = 6'd39;
    localparam logic [5:0] K_LPAR = 6'd40;
    localparam logic [5:0] K_RPAR = 6'd41;
    localparam logic [5:0] K_COMMA = 6'd42;
    localparam logic [5:0] K_DCOLON = 6'd43;
    localparam logic [5:0] K_ERR = 6'd44;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    localparam int NUM_KW = 21;
    localparam int KW_CHARS = 10;

    // Keywords, first character in the lowest byte, zero padded.
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        80'h4D4152474F5250, 80'h444E45,
        80'h4E4F4954434E5546, 80'h454E4954554F52425553,
        80'h52454745544E49, 80'h544E45544E49, 80'h4E49,
        80'h54554F4E49, 80'h4649, 80'h4E454854, 80'h45534C45,
        80'h464945534C45, 80'h4F44, 80'h454C494857, 80'h544E495250,
        80'h44414552, 80'h4C4C4143, 80'h4E5255544552, 80'h504F5453,
        80'h54495845, 80'h454C435943
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd7, 4'd3, 4'd8, 4'd10, 4'd7, 4'd6, 4'd2, 4'd5, 4'd2, 4'd4, 4'd4,
        4'd6, 4'd2, 4'd5, 4'd5, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5
    };

    typedef enum logic [7:0] {
        M_IDLE = 8'b0000_0001,
        M_COMMENT = 8'b0000_0010,
        M_IDENT = 8'b0000_0100,
        M_NUMBER = 8'b0000_1000,
        M_STRING = 8'b0001_0000,
        M_DOT = 8'b0010_0000,
        M_DOTWORD = 8'b0100_0000,
        M_OPWAIT = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [5:0] kind;
        logic [15:0] line;
        logic [23:0] start;
        logic [15:0] len;
        logic [30:0] ival;
        logic [7:0] bad;
    } token_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5F;
    endfunction

    function automatic logic [7:0] to_up(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v != LEN_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

@@ hw/rtl/fst_queue.sv @@
// ----------------------------------------------------------------------------
// Token output queue
// Holds up to four tokens of one input beat and issues them one per beat.
// ----------------------------------------------------------------------------
module fst_queue
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [fst_pkg::CNT_BITS-1:0]            load_count,
    input  fst_pkg::token_t [fst_pkg::MAX_TOKENS-1:0] load_tokens,
    output logic                                    can_load,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output fst_pkg::token_t                         out_token,
    output logic                                    out_last
);

    fst_pkg::token_t [fst_pkg::MAX_TOKENS-1:0] tok_reg;
    logic [fst_pkg::CNT_BITS-1:0] cnt_reg;
    logic [fst_pkg::CNT_BITS-1:0] idx_reg;
    logic pop;

    assign out_valid = (idx_reg != cnt_reg);
    assign pop = out_valid && out_ready;
    assign out_token = tok_reg[idx_reg[1:0]];
    assign out_last = (idx_reg + 3'd1 == cnt_reg);
    // The queue refills in the cycle its last token leaves.
    assign can_load = !out_valid || (pop && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load && can_load)
        begin
            cnt_reg <= load_count;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            tok_reg <= load_tokens;
        end
    end

endmodule

@@ hw/rtl/fst_lexer.sv @@
// ----------------------------------------------------------------------------
// Lexer step
// Combinational next-state and token generation for one source byte.
// ----------------------------------------------------------------------------
module fst_lexer #(
    parameter int KEYWORD_MAX_LEN = 10,
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS = 16
)
(
    input  logic                    action,
    input  logic [7:0]              c,
    input  fst_pkg::mode_t          mode,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [LINE_BITS-1:0]    lcount,
    input  logic [POSITION_BITS-1:0] tstart,
    input  logic [LINE_BITS-1:0]    tline,
    input  logic [15:0]             rlen,
    input  logic [30:0]             acc,
    input  logic [7:0]              qchar,
    input  logic [7:0]              pchar,
    input  logic [7:0]              wbuf [KEYWORD_MAX_LEN],
    input  logic [7:0]              dbuf [5],
    output fst_pkg::mode_t          mode_n,
    output logic [POSITION_BITS-1:0] pos_n,
    output logic [LINE_BITS-1:0]    lcount_n,
    output logic [POSITION_BITS-1:0] tstart_n,
    output logic [LINE_BITS-1:0]    tline_n,
    output logic [15:0]             rlen_n,
    output logic [30:0]             acc_n,
    output logic [7:0]              qchar_n,
    output logic [7:0]              pchar_n,
    output logic [7:0]              wbuf_n [KEYWORD_MAX_LEN],
    output logic [7:0]              dbuf_n [5],
    output fst_pkg::token_t [fst_pkg::MAX_TOKENS-1:0] toks,
    output logic [fst_pkg::CNT_BITS-1:0] ntok
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LINE_BITS-1:0] LN_MAX = '1;

    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [23:0] sat_pos(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
    endfunction

    function automatic logic [5:0] word_kind(input logic [15:0] n,
                                             input logic [7:0] b [KEYWORD_MAX_LEN]);
        logic [5:0] k;
        logic hit;
        k = fst_pkg::K_ID;
        for (int i = fst_pkg::NUM_KW - 1; i >= 0; i--)
        begin
            hit = (n == 16'(fst_pkg::KW_LEN[i]));
            for (int j = 0; j < fst_pkg::KW_CHARS; j++)
            begin
                if (j < fst_pkg::KW_LEN[i] && b[j] != fst_pkg::KW_TEXT[i][8*j +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                k = fst_pkg::K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

    always_comb
    begin
        logic [POSITION_BITS-1:0] after_dot;
        logic [POSITION_BITS-1:0] pos1;
        logic [15:0] tl16;
        logic [15:0] ln16;
        logic [23:0] ts24;
        logic [5:0] wk;
        logic [5:0] op1;
        logic [5:0] op2;
        logic do_idle;
        logic [34:0] prod;
        int n;
        logic [5:0] dk;
        logic dok;
        logic [30:0] dval;

        mode_n = mode;
        pos_n = pos;
        lcount_n = lcount;
        tstart_n = tstart;
        tline_n = tline;
        rlen_n = rlen;
        acc_n = acc;
        qchar_n = qchar;
        pchar_n = pchar;
        wbuf_n = wbuf;
        dbuf_n = dbuf;
        toks = '0;
        n = 0;
        do_idle = 1'b0;
        after_dot = (tstart != POS_MAX) ? tstart + 1'b1 : POS_MAX;
        pos1 = (pos != POS_MAX) ? pos + 1'b1 : POS_MAX;
        tl16 = sat_line(tline);
        ln16 = sat_line(lcount);
        ts24 = sat_pos(tstart);
        wk = (rlen <= 16'(KEYWORD_MAX_LEN)) ? word_kind(rlen, wbuf) : fst_pkg::K_ID;
        prod = {4'd0, acc} * 35'd10 + 35'(c - 8'h30);

        case (pchar)
            fst_pkg::CH_EQ: op1 = fst_pkg::K_ASSIGN;
            fst_pkg::CH_SLASH: op1 = fst_pkg::K_SLASH;
            fst_pkg::CH_LT: op1 = fst_pkg::K_LT;
            fst_pkg::CH_GT: op1 = fst_pkg::K_GT;
            default: op1 = fst_pkg::K_ERR;
        endcase
        op2 = 6'd0;
        if (pchar == fst_pkg::CH_COLON && c == fst_pkg::CH_COLON)
        begin
            op2 = fst_pkg::K_DCOLON;
        end
        else if (c == fst_pkg::CH_EQ)
        begin
            case (pchar)
                fst_pkg::CH_EQ: op2 = fst_pkg::K_EQ;
                fst_pkg::CH_SLASH: op2 = fst_pkg::K_NE;
                fst_pkg::CH_LT: op2 = fst_pkg::K_LE;
                fst_pkg::CH_GT: op2 = fst_pkg::K_GE;
                default: op2 = 6'd0;
            endcase
        end

        dk = 6'd0;
        dval = '0;
        dok = 1'b1;
        if (rlen == 16'd3 && dbuf[0] == 8'h41 && dbuf[1] == 8'h4E && dbuf[2] == 8'h44)
            dk = fst_pkg::K_AND;
        else if (rlen == 16'd2 && dbuf[0] == 8'h4F && dbuf[1] == 8'h52)
            dk = fst_pkg::K_OR;
        else if (rlen == 16'd3 && dbuf[0] == 8'h4E && dbuf[1] == 8'h4F && dbuf[2] == 8'h54)
            dk = fst_pkg::K_NOT;
        else if (rlen == 16'd4 && dbuf[0] == 8'h54 && dbuf[1] == 8'h52
                 && dbuf[2] == 8'h55 && dbuf[3] == 8'h45)
        begin
            dk = fst_pkg::K_INT;
            dval = 31'd1;
        end
        else if (rlen == 16'd5 && dbuf[0] == 8'h46 && dbuf[1] == 8'h41
                 && dbuf[2] == 8'h4C && dbuf[3] == 8'h53 && dbuf[4] == 8'h45)
            dk = fst_pkg::K_INT;
        else
            dok = 1'b0;

        if (action)
        begin
            case (mode)
                fst_pkg::M_STRING:
                begin
                    toks[n] = '{fst_pkg::K_STR, tl16, ts24, rlen, 31'd0, 8'd0};
                    n++;
                end
                fst_pkg::M_NUMBER:
                begin
                    toks[n] = '{fst_pkg::K_INT, tl16, ts24, rlen, acc, 8'd0};
                    n++;
                end
                fst_pkg::M_IDENT:
                begin
                    toks[n] = '{wk, tl16, ts24, rlen, 31'd0, 8'd0};
                    n++;
                end
                fst_pkg::M_DOT:
                begin
                    toks[n] = '{fst_pkg::K_ERR, tl16, ts24, 16'd1, 31'd0, fst_pkg::CH_DOT};
                    n++;
                end
                fst_pkg::M_DOTWORD:
                begin
                    toks[n] = '{fst_pkg::K_ERR, tl16, ts24, 16'd1, 31'd0, fst_pkg::CH_DOT};
                    n++;
                    toks[n] = '{wk, tl16, sat_pos(after_dot), rlen, 31'd0, 8'd0};
                    n++;
                end
                fst_pkg::M_OPWAIT:
                begin
                    toks[n] = '{op1, tl16, ts24, 16'd1, 31'd0,
                                (op1 == fst_pkg::K_ERR) ? pchar : 8'd0};
                    n++;
                end
                default: ;
            endcase
            toks[n] = '{fst_pkg::K_EOF, ln16, sat_pos(pos), 16'd0, 31'd0, 8'd0};
            n++;
            mode_n = fst_pkg::M_IDLE;
            pos_n = '0;
            lcount_n = LINE_BITS'(1);
            tstart_n = '0;
            tline_n = LINE_BITS'(1);
            rlen_n = '0;
            acc_n = '0;
            qchar_n = '0;
            pchar_n = '0;
        end
        else
        begin
            case (mode)
                fst_pkg::M_COMMENT: do_idle = (c == fst_pkg::CH_NL);
                fst_pkg::M_STRING:
                begin
                    if (c == qchar || c == fst_pkg::CH_NL)
                    begin
                        toks[n] = '{fst_pkg::K_STR, tl16, ts24, rlen, 31'd0, 8'd0};
                        n++;
                        mode_n = fst_pkg::M_IDLE;
                        do_idle = (c != qchar);
                    end
                    else
                        rlen_n = fst_pkg::inc16(rlen);
                end
                fst_pkg::M_NUMBER:
                begin
                    if (fst_pkg::is_digit(c))
                    begin
                        acc_n = (prod > 35'(fst_pkg::INT_MAXV)) ? fst_pkg::INT_MAXV
                                                                : prod[30:0];
                        rlen_n = fst_pkg::inc16(rlen);
                    end
                    else
                    begin
                        toks[n] = '{fst_pkg::K_INT, tl16, ts24, rlen, acc, 8'd0};
                        n++;
                        do_idle = 1'b1;
                    end
                end
                fst_pkg::M_IDENT:
                begin
                    if (fst_pkg::is_word(c))
                    begin
                        if (rlen < 16'(KEYWORD_MAX_LEN))
                            wbuf_n[rlen[$clog2(KEYWORD_MAX_LEN)-1:0]] = fst_pkg::to_up(c);
                        rlen_n = fst_pkg::inc16(rlen);
                    end
                    else
                    begin
                        toks[n] = '{wk, tl16, ts24, rlen, 31'd0, 8'd0};
                        n++;
                        do_idle = 1'b1;
                    end
                end
                fst_pkg::M_DOT:
                begin
                    if (fst_pkg::is_alpha(c))
                    begin
                        dbuf_n[0] = fst_pkg::to_up(c);
                        wbuf_n[0] = fst_pkg::to_up(c);
                        rlen_n = 16'd1;
                        mode_n = fst_pkg::M_DOTWORD;
                    end
                    else
                    begin
                        toks[n] = '{fst_pkg::K_ERR, tl16, ts24, 16'd1, 31'd0,
                                    fst_pkg::CH_DOT};
                        n++;
                        do_idle = 1'b1;
                    end
                end
                fst_pkg::M_DOTWORD:
                begin
                    if (fst_pkg::is_alpha(c))
                    begin
                        if (rlen < 16'd5)
                            dbuf_n[rlen[2:0]] = fst_pkg::to_up(c);
                        if (rlen < 16'(KEYWORD_MAX_LEN))
                            wbuf_n[rlen[$clog2(KEYWORD_MAX_LEN)-1:0]] = fst_pkg::to_up(c);
                        rlen_n = fst_pkg::inc16(rlen);
                    end
                    else if (c == fst_pkg::CH_DOT && dok)
                    begin
                        toks[n] = '{dk, tl16, ts24, rlen + 16'd2, dval, 8'd0};
                        n++;
                        mode_n = fst_pkg::M_IDLE;
                    end
                    else
                    begin
                        toks[n] = '{fst_pkg::K_ERR, tl16, ts24, 16'd1, 31'd0,
                                    fst_pkg::CH_DOT};
                        n++;
                        if (c != fst_pkg::CH_DOT && fst_pkg::is_word(c))
                        begin
                            // The dotted word becomes an identifier after the dot.
                            tstart_n = after_dot;
                            if (rlen < 16'(KEYWORD_MAX_LEN))
                                wbuf_n[rlen[$clog2(KEYWORD_MAX_LEN)-1:0]] =
                                    fst_pkg::to_up(c);
                            rlen_n = fst_pkg::inc16(rlen);
                            mode_n = fst_pkg::M_IDENT;
                        end
                        else
                        begin
                            toks[n] = '{wk, tl16, sat_pos(after_dot), rlen, 31'd0, 8'd0};
                            n++;
                            do_idle = 1'b1;
                        end
                    end
                end
                fst_pkg::M_OPWAIT:
                begin
                    if (op2 != 6'd0)
                    begin
                        toks[n] = '{op2, tl16, ts24, 16'd2, 31'd0, 8'd0};
                        n++;
                        mode_n = fst_pkg::M_IDLE;
                    end
                    else
                    begin
                        toks[n] = '{op1, tl16, ts24, 16'd1, 31'd0,
                                    (op1 == fst_pkg::K_ERR) ? pchar : 8'd0};
                        n++;
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_idle)
            begin
                mode_n = fst_pkg::M_IDLE;
                if (c == 8'h20 || c == 8'h09 || c == 8'h0D)
                begin
                end
                else if (c == fst_pkg::CH_NL || c == fst_pkg::CH_SEMI)
                begin
                    toks[n] = '{fst_pkg::K_NL, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                    n++;
                end
                else if (c == fst_pkg::CH_BANG)
                    mode_n = fst_pkg::M_COMMENT;
                else if (c == 8'h22 || c == 8'h27)
                begin
                    tstart_n = pos1;
                    tline_n = lcount;
                    rlen_n = '0;
                    qchar_n = c;
                    mode_n = fst_pkg::M_STRING;
                end
                else if (fst_pkg::is_digit(c))
                begin
                    tstart_n = pos;
                    tline_n = lcount;
                    acc_n = 31'(c - 8'h30);
                    rlen_n = 16'd1;
                    mode_n = fst_pkg::M_NUMBER;
                end
                else if (fst_pkg::is_word(c))
                begin
                    tstart_n = pos;
                    tline_n = lcount;
                    wbuf_n[0] = fst_pkg::to_up(c);
                    rlen_n = 16'd1;
                    mode_n = fst_pkg::M_IDENT;
                end
                else if (c == fst_pkg::CH_DOT)
                begin
                    tstart_n = pos;
                    tline_n = lcount;
                    rlen_n = '0;
                    mode_n = fst_pkg::M_DOT;
                end
                else if (c == fst_pkg::CH_COLON || c == fst_pkg::CH_EQ
                         || c == fst_pkg::CH_SLASH || c == fst_pkg::CH_LT
                         || c == fst_pkg::CH_GT)
                begin
                    tstart_n = pos;
                    tline_n = lcount;
                    rlen_n = '0;
                    pchar_n = c;
                    mode_n = fst_pkg::M_OPWAIT;
                end
                else
                begin
                    case (c)
                        8'h2B: toks[n] = '{fst_pkg::K_PLUS, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        8'h2D: toks[n] = '{fst_pkg::K_MINUS, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        8'h2A: toks[n] = '{fst_pkg::K_STAR, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        8'h28: toks[n] = '{fst_pkg::K_LPAR, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        8'h29: toks[n] = '{fst_pkg::K_RPAR, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        8'h2C: toks[n] = '{fst_pkg::K_COMMA, ln16, sat_pos(pos), 16'd1, 31'd0, 8'd0};
                        default: toks[n] = '{fst_pkg::K_ERR, ln16, sat_pos(pos), 16'd1, 31'd0, c};
                    endcase
                    n++;
                end
            end

            if (c == fst_pkg::CH_NL && lcount != LN_MAX)
                lcount_n = lcount + 1'b1;
            pos_n = pos1;
        end
        ntok = fst_pkg::CNT_BITS'(n);
    end

endmodule

@@ hw/rtl/fortran_subset_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Fortran subset tokenizer
// Streaming lexer: one source byte per beat in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_axis   in   tdata: char_code[7:0]; tuser: action
// m_axis   out  tdata: kind, line, start, length, literal_value, bad_char; tlast
//
// One byte is lexed per cycle while the token queue can load, by the lexer
// step between the scan state registers and the token queue. A byte that
// yields tokens holds off the next byte until the queue has drained.
// Reset clears the scan state but not the word buffers, and empties the queue.
// The end marker emits EOF and returns the scan state to its reset values.
// ----------------------------------------------------------------------------
module fortran_subset_tokenizer #(
    parameter int KEYWORD_MAX_LEN = 10,
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // char_code
    input  logic         s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_kind[5:0], line_number[21:6], start_offset[45:22],
    // token_length[61:46], literal_value[92:62], bad_char[100:93], zero pad
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    fst_pkg::mode_t mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, tstart_reg, tstart_next;
    logic [LINE_BITS-1:0] line_reg, line_next, tline_reg, tline_next;
    logic [15:0] rlen_reg, rlen_next;
    logic [30:0] acc_reg, acc_next;
    logic [7:0] qchar_reg, qchar_next, pchar_reg, pchar_next;
    logic [7:0] wbuf_reg [KEYWORD_MAX_LEN];
    logic [7:0] wbuf_next [KEYWORD_MAX_LEN];
    logic [7:0] dbuf_reg [5];
    logic [7:0] dbuf_next [5];
    fst_pkg::token_t [fst_pkg::MAX_TOKENS-1:0] toks;
    logic [fst_pkg::CNT_BITS-1:0] ntok;
    logic can_load, take;
    fst_pkg::token_t otok;

    assign s_axis_tready = can_load;
    assign take = s_axis_tvalid && can_load;

    fst_lexer #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .POSITION_BITS(POSITION_BITS),
        .LINE_BITS(LINE_BITS)
    ) u_lexer (
        .action(s_axis_tuser), .c(s_axis_tdata), .mode(mode_reg), .pos(pos_reg),
        .lcount(line_reg), .tstart(tstart_reg), .tline(tline_reg), .rlen(rlen_reg),
        .acc(acc_reg), .qchar(qchar_reg), .pchar(pchar_reg), .wbuf(wbuf_reg),
        .dbuf(dbuf_reg), .mode_n(mode_next), .pos_n(pos_next), .lcount_n(line_next),
        .tstart_n(tstart_next), .tline_n(tline_next), .rlen_n(rlen_next),
        .acc_n(acc_next), .qchar_n(qchar_next), .pchar_n(pchar_next),
        .wbuf_n(wbuf_next), .dbuf_n(dbuf_next), .toks(toks), .ntok(ntok)
    );

    fst_queue u_queue (
        .clk(clk), .rst_n(rst_n), .load(take && ntok != '0), .load_count(ntok),
        .load_tokens(toks), .can_load(can_load), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .out_token(otok), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, otok.bad, otok.ival, otok.len, otok.start,
                           otok.line, otok.kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fst_pkg::M_IDLE;
            pos_reg <= '0;
            line_reg <= LINE_BITS'(1);
            tstart_reg <= '0;
            tline_reg <= LINE_BITS'(1);
            rlen_reg <= '0;
            acc_reg <= '0;
            qchar_reg <= '0;
            pchar_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            tstart_reg <= tstart_next;
            tline_reg <= tline_next;
            rlen_reg <= rlen_next;
            acc_reg <= acc_next;
            qchar_reg <= qchar_next;
            pchar_reg <= pchar_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wbuf_reg <= wbuf_next;
            dbuf_reg <= dbuf_next;
        end
    end

endmodule

@@ dv/tb_fortran_subset_tokenizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fortran subset tokenizer testbench
// Feeds source byte streams and end markers through the slave channel, works
// out the expected tokens with an independent lexer model and checks every
// token beat on the master channel, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_fortran_subset_tokenizer;

    localparam int CYCLE_LIMIT = 200000;
    localparam int KW_KEEP = 10;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [23:0] start;
        logic [15:0] len;
        logic [30:0] ival;
        logic [7:0]  bad;
        logic        last;
    } exp_tok_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;

    fortran_subset_tokenizer u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Source beats waiting to be sent: {end marker, byte}.
    logic [8:0] src_q[$];
    exp_tok_t   token_q[$];
    exp_tok_t   step_toks[$];

    int errors = 0;
    int bytes_sent = 0;
    int ends_sent = 0;
    int tokens_seen = 0;
    int cycles = 0;

    // Lexer state of the model.
    fst_pkg::mode_t lx_mode;
    logic [23:0] lx_pos;
    logic [15:0] lx_line;
    logic [23:0] lx_tstart;
    logic [15:0] lx_tline;
    logic [15:0] lx_rlen;
    logic [30:0] lx_acc;
    logic [7:0]  lx_quote;
    logic [7:0]  lx_pend;
    logic [7:0]  lx_word[KW_KEEP];
    logic [7:0]  lx_dot[5];

    string kw_names[21] = '{"PROGRAM", "END", "FUNCTION", "SUBROUTINE", "INTEGER",
        "INTENT", "IN", "INOUT", "IF", "THEN", "ELSE", "ELSEIF", "DO", "WHILE",
        "PRINT", "READ", "CALL", "RETURN", "STOP", "EXIT", "CYCLE"};

    function automatic bit letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return letter(c) || numeral(c) || c == "_";
    endfunction

    function automatic logic [7:0] upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic logic [23:0] next_pos(logic [23:0] p);
        return (p != 24'hFFFFFF) ? p + 24'd1 : p;
    endfunction

    task automatic lx_reset();
        lx_mode = fst_pkg::M_IDLE;
        lx_pos = '0;
        lx_line = 16'd1;
        lx_tstart = '0;
        lx_tline = 16'd1;
        lx_rlen = '0;
        lx_acc = '0;
        lx_quote = '0;
        lx_pend = '0;
        foreach (lx_word[i]) lx_word[i] = '0;
        foreach (lx_dot[i]) lx_dot[i] = '0;
    endtask

    function automatic void put(logic [5:0] kind, logic [15:0] line, logic [23:0] start,
                                int unsigned len, int unsigned ival, int unsigned bad);
        exp_tok_t t;
        t.kind = kind;
        t.line = line;
        t.start = start;
        t.len = (len > 32'hFFFF) ? 16'hFFFF : 16'(len);
        t.ival = 31'(ival);
        t.bad = 8'(bad);
        t.last = 1'b0;
        if (step_toks.size() < fst_pkg::MAX_TOKENS)
            step_toks.push_back(t);
    endfunction

    task automatic word_add(logic [7:0] c);
        if (lx_rlen < KW_KEEP)
            lx_word[lx_rlen] = upper(c);
        lx_rlen = bump(lx_rlen);
    endtask

    task automatic emit_word(logic [23:0] start);
        logic [5:0] kind;
        bit hit;
        kind = fst_pkg::K_ID;
        if (lx_rlen <= KW_KEEP)
        begin
            for (int k = 0; k < 21; k++)
            begin
                if (kw_names[k].len() == lx_rlen && kind == fst_pkg::K_ID)
                begin
                    hit = 1;
                    for (int j = 0; j < kw_names[k].len(); j++)
                        if (lx_word[j] != kw_names[k][j]) hit = 0;
                    if (hit) kind = fst_pkg::K_KW0 + 6'(k);
                end
            end
        end
        put(kind, lx_tline, start, lx_rlen, 0, 0);
    endtask

    task automatic emit_single();
        case (lx_pend)
            fst_pkg::CH_EQ:    put(fst_pkg::K_ASSIGN, lx_tline, lx_tstart, 1, 0, 0);
            fst_pkg::CH_SLASH: put(fst_pkg::K_SLASH, lx_tline, lx_tstart, 1, 0, 0);
            fst_pkg::CH_LT:    put(fst_pkg::K_LT, lx_tline, lx_tstart, 1, 0, 0);
            fst_pkg::CH_GT:    put(fst_pkg::K_GT, lx_tline, lx_tstart, 1, 0, 0);
            default:           put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, lx_pend);
        endcase
    endtask

    task automatic begin_token(logic [23:0] p);
        lx_tstart = p;
        lx_tline = lx_line;
        lx_rlen = '0;
    endtask

    task automatic idle_byte(logic [7:0] c, logic [23:0] p);
        lx_mode = fst_pkg::M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0D)
            return;
        if (c == fst_pkg::CH_NL || c == fst_pkg::CH_SEMI)
            put(fst_pkg::K_NL, lx_line, p, 1, 0, 0);
        else if (c == fst_pkg::CH_BANG)
            lx_mode = fst_pkg::M_COMMENT;
        else if (c == "\"" || c == "'")
        begin
            begin_token(next_pos(p));
            lx_quote = c;
            lx_mode = fst_pkg::M_STRING;
        end
        else if (numeral(c))
        begin
            begin_token(p);
            lx_acc = 31'(c - 8'h30);
            lx_rlen = 16'd1;
            lx_mode = fst_pkg::M_NUMBER;
        end
        else if (letter(c) || c == "_")
        begin
            begin_token(p);
            word_add(c);
            lx_mode = fst_pkg::M_IDENT;
        end
        else if (c == fst_pkg::CH_DOT)
        begin
            begin_token(p);
            lx_mode = fst_pkg::M_DOT;
        end
        else if (c == fst_pkg::CH_COLON || c == fst_pkg::CH_EQ || c == fst_pkg::CH_SLASH
                 || c == fst_pkg::CH_LT || c == fst_pkg::CH_GT)
        begin
            begin_token(p);
            lx_pend = c;
            lx_mode = fst_pkg::M_OPWAIT;
        end
        else
        begin
            case (c)
                "+":     put(fst_pkg::K_PLUS, lx_line, p, 1, 0, 0);
                "-":     put(fst_pkg::K_MINUS, lx_line, p, 1, 0, 0);
                "*":     put(fst_pkg::K_STAR, lx_line, p, 1, 0, 0);
                "(":     put(fst_pkg::K_LPAR, lx_line, p, 1, 0, 0);
                ")":     put(fst_pkg::K_RPAR, lx_line, p, 1, 0, 0);
                ",":     put(fst_pkg::K_COMMA, lx_line, p, 1, 0, 0);
                default: put(fst_pkg::K_ERR, lx_line, p, 1, 0, c);
            endcase
        end
    endtask

    function automatic bit dot_word_is(string w);
        if (lx_rlen != w.len()) return 0;
        for (int i = 0; i < w.len(); i++)
            if (lx_dot[i] != w[i]) return 0;
        return 1;
    endfunction

    function automatic bit dot_op_done();
        int unsigned len;
        len = lx_rlen + 2;
        if (dot_word_is("AND")) put(fst_pkg::K_AND, lx_tline, lx_tstart, len, 0, 0);
        else if (dot_word_is("OR")) put(fst_pkg::K_OR, lx_tline, lx_tstart, len, 0, 0);
        else if (dot_word_is("NOT")) put(fst_pkg::K_NOT, lx_tline, lx_tstart, len, 0, 0);
        else if (dot_word_is("TRUE")) put(fst_pkg::K_INT, lx_tline, lx_tstart, len, 1, 0);
        else if (dot_word_is("FALSE")) put(fst_pkg::K_INT, lx_tline, lx_tstart, len, 0, 0);
        else return 0;
        return 1;
    endfunction

    // Works out the tokens that one accepted source beat causes.
    task automatic lex_beat(logic is_end, logic [7:0] c);
        logic [23:0] p;
        logic [5:0] k;
        logic [34:0] v;
        p = lx_pos;
        step_toks.delete();
        if (is_end)
        begin
            case (lx_mode)
                fst_pkg::M_STRING: put(fst_pkg::K_STR, lx_tline, lx_tstart, lx_rlen, 0, 0);
                fst_pkg::M_NUMBER:
                    put(fst_pkg::K_INT, lx_tline, lx_tstart, lx_rlen, lx_acc, 0);
                fst_pkg::M_IDENT:  emit_word(lx_tstart);
                fst_pkg::M_DOT:
                    put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, fst_pkg::CH_DOT);
                fst_pkg::M_DOTWORD:
                begin
                    put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, fst_pkg::CH_DOT);
                    emit_word(next_pos(lx_tstart));
                end
                fst_pkg::M_OPWAIT: emit_single();
                default: ;
            endcase
            put(fst_pkg::K_EOF, lx_line, lx_pos, 0, 0, 0);
            lx_reset();
        end
        else
        begin
            case (lx_mode)
                fst_pkg::M_COMMENT:
                    if (c == fst_pkg::CH_NL) idle_byte(c, p);
                fst_pkg::M_STRING:
                    if (c == lx_quote)
                    begin
                        put(fst_pkg::K_STR, lx_tline, lx_tstart, lx_rlen, 0, 0);
                        lx_mode = fst_pkg::M_IDLE;
                    end
                    else if (c == fst_pkg::CH_NL)
                    begin
                        put(fst_pkg::K_STR, lx_tline, lx_tstart, lx_rlen, 0, 0);
                        idle_byte(c, p);
                    end
                    else
                        lx_rlen = bump(lx_rlen);
                fst_pkg::M_NUMBER:
                    if (numeral(c))
                    begin
                        v = 35'(lx_acc) * 35'd10 + 35'(c - 8'h30);
                        lx_acc = (v > 35'(fst_pkg::INT_MAXV)) ? fst_pkg::INT_MAXV : v[30:0];
                        lx_rlen = bump(lx_rlen);
                    end
                    else
                    begin
                        put(fst_pkg::K_INT, lx_tline, lx_tstart, lx_rlen, lx_acc, 0);
                        idle_byte(c, p);
                    end
                fst_pkg::M_IDENT:
                    if (word_char(c)) word_add(c);
                    else
                    begin
                        emit_word(lx_tstart);
                        idle_byte(c, p);
                    end
                fst_pkg::M_DOT:
                    if (letter(c))
                    begin
                        lx_rlen = '0;
                        lx_dot[0] = upper(c);
                        word_add(c);
                        lx_mode = fst_pkg::M_DOTWORD;
                    end
                    else
                    begin
                        put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, fst_pkg::CH_DOT);
                        idle_byte(c, p);
                    end
                fst_pkg::M_DOTWORD:
                    if (letter(c))
                    begin
                        if (lx_rlen < 5) lx_dot[lx_rlen] = upper(c);
                        word_add(c);
                    end
                    else if (c == fst_pkg::CH_DOT)
                    begin
                        if (dot_op_done())
                            lx_mode = fst_pkg::M_IDLE;
                        else
                        begin
                            put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, fst_pkg::CH_DOT);
                            emit_word(next_pos(lx_tstart));
                            idle_byte(c, p);
                        end
                    end
                    else
                    begin
                        // The letters after a bad dot are lexed again as a word.
                        put(fst_pkg::K_ERR, lx_tline, lx_tstart, 1, 0, fst_pkg::CH_DOT);
                        if (word_char(c))
                        begin
                            lx_tstart = next_pos(lx_tstart);
                            word_add(c);
                            lx_mode = fst_pkg::M_IDENT;
                        end
                        else
                        begin
                            emit_word(next_pos(lx_tstart));
                            idle_byte(c, p);
                        end
                    end
                fst_pkg::M_OPWAIT:
                begin
                    k = '0;
                    if (lx_pend == fst_pkg::CH_COLON && c == fst_pkg::CH_COLON)
                        k = fst_pkg::K_DCOLON;
                    else if (c == fst_pkg::CH_EQ)
                    begin
                        if (lx_pend == fst_pkg::CH_EQ) k = fst_pkg::K_EQ;
                        else if (lx_pend == fst_pkg::CH_SLASH) k = fst_pkg::K_NE;
                        else if (lx_pend == fst_pkg::CH_LT) k = fst_pkg::K_LE;
                        else if (lx_pend == fst_pkg::CH_GT) k = fst_pkg::K_GE;
                    end
                    if (k != '0)
                    begin
                        put(k, lx_tline, lx_tstart, 2, 0, 0);
                        lx_mode = fst_pkg::M_IDLE;
                    end
                    else
                    begin
                        emit_single();
                        idle_byte(c, p);
                    end
                end
                default: idle_byte(c, p);
            endcase
            if (c == fst_pkg::CH_NL && lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
            lx_pos = next_pos(lx_pos);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
    endtask

    task automatic add_end();
        src_q.push_back({1'b1, 8'($urandom)});
    endtask

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        return (letter(c) && $urandom_range(0, 1)) ? (c | 8'h20) : c;
    endfunction

    task automatic add_fragment();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 15))
            0, 1:
            begin
                s = kw_names[$urandom_range(0, 20)];
                foreach (s[i]) s[i] = mixed_case(s[i]);
            end
            2:
            begin
                n = $urandom_range(1, 14);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
                        1: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
                        2: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
                        default: s = {s, "_"};
                    endcase
                end
                if (numeral(s[0])) s[0] = "x";
            end
            3:
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            end
            4:
            begin
                s = $urandom_range(0, 1) ? "\"" : "'";
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
                case ($urandom_range(0, 3))
                    0: s = {s, "\n"};
                    default: s = {s, string'(s[0])};
                endcase
            end
            5:
            begin
                case ($urandom_range(0, 8))
                    0: s = ".AND."; 1: s = ".or."; 2: s = ".Not."; 3: s = ".TRUE.";
                    4: s = ".false."; 5: s = ".ab."; 6: s = ".andx "; 7: s = ".5";
                    default: s = ".q1";
                endcase
                foreach (s[i]) s[i] = mixed_case(s[i]);
            end
            6, 7:
            begin
                case ($urandom_range(0, 14))
                    0: s = "=="; 1: s = "/="; 2: s = "<="; 3: s = ">="; 4: s = "::";
                    5: s = "="; 6: s = "/"; 7: s = "<"; 8: s = ">"; 9: s = ":";
                    10: s = "+"; 11: s = "-"; 12: s = "*"; 13: s = "(";
                    default: s = $urandom_range(0, 1) ? ")" : ",";
                endcase
            end
            8, 9: s = $urandom_range(0, 3) ? " " : "\t";
            10: s = $urandom_range(0, 2) ? "\n" : ";";
            11: s = "! note (x) 'q\n";
            12: s = "\r";
            13: s = string'(8'($urandom_range(0, 255)));
            default: s = " ";
        endcase
        add_text(s);
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    int  send_gap;
    bit  drain_wait;
    bit  drain_done;
    bit  burst_mode;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            send_gap <= 0;
            drain_wait <= 1'b0;
            drain_done <= 1'b0;
            burst_mode <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lex_beat(s_axis_tuser, s_axis_tdata);
                if (s_axis_tuser) ends_sent++;
                else bytes_sent++;
                if (bytes_sent == 250 && !drain_done) drain_wait <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) burst_mode <= ~burst_mode;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                // Pause once with nothing outstanding before continuing.
                if (drain_wait && token_q.size() == 0 && !s_axis_tvalid)
                begin
                    drain_wait <= 1'b0;
                    drain_done <= 1'b1;
                end
                if (send_gap == 0 && !drain_wait && src_q.size() > 0)
                begin
                    {s_axis_tuser, s_axis_tdata} <= src_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    int  hold_cnt;
    bit  hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        exp_tok_t e;
        exp_tok_t a;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                a.kind = m_axis_tdata[5:0];
                a.line = m_axis_tdata[21:6];
                a.start = m_axis_tdata[45:22];
                a.len = m_axis_tdata[61:46];
                a.ival = m_axis_tdata[92:62];
                a.bad = m_axis_tdata[100:93];
                a.last = m_axis_tlast;
                tokens_seen++;
                if (token_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected token kind %0d line %0d start %0d",
                             $time, a.kind, a.line, a.start);
                end
                else
                begin
                    e = token_q.pop_front();
                    if (e.kind != a.kind || e.line != a.line || e.start != a.start
                        || e.len != a.len || e.ival != a.ival || e.bad != a.bad
                        || e.last != a.last || m_axis_tdata[103:101] != '0)
                    begin
                        errors++;
                        $display("%0t: token mismatch expected k=%0d ln=%0d st=%0d len=%0d val=%0d bad=%h last=%b",
                                 $time, e.kind, e.line, e.start, e.len, e.ival, e.bad, e.last);
                        $display("%0t:                actual   k=%0d ln=%0d st=%0d len=%0d val=%0d bad=%h last=%b",
                                 $time, a.kind, a.line, a.start, a.len, a.ival, a.bad, a.last);
                    end
                end
            end
            // One long hold-off so that the block backs up into its input.
            if (bytes_sent >= 100 && !hold_done && hold_cnt == 0)
            begin
                hold_cnt <= 300;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_axis_tready <= (hold_cnt == 1);
            end
            else if (!burst_mode && $urandom_range(0, 199) == 0)
            begin
                hold_cnt <= $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end
            else if (burst_mode)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // ------------------------------------------------------------------
    // Clock, reset, sequencing and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        lx_reset();
        rst_n = 1'b0;
        // Directed: operators, dot forms, a bad dot, a saturating number,
        // an unterminated string, a lone colon and a high byte.
        add_text("IF(a/=9).TRUE.:x");
        src_q.push_back({1'b0, 8'hFF});
        add_end();
        add_text("99999999999 .xy1 'ab");
        add_end();
        add_text("subroutine q !c");
        add_end();
        add_text(".ab");
        add_end();
        while (src_q.size() < 415)
        begin
            add_fragment();
            if ($urandom_range(0, 39) == 0) add_end();
        end
        add_text("< ");
        add_end();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (src_q.size() == 0);
        @(posedge clk);
        wait (!s_axis_tvalid);
        wait (token_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("Sent %0d source bytes and %0d end markers; checked %0d tokens.",
                 bytes_sent, ends_sent, tokens_seen);
        if (errors == 0 && token_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fst_pkg.sv
hw/rtl/fst_queue.sv
hw/rtl/fst_lexer.sv
hw/rtl/fortran_subset_tokenizer.sv
dv/tb_fortran_subset_tokenizer.sv
